// File: hdl/mfb_pkg.sv
// Shared types, command codes and helper functions of the monochrome framebuffer draw engine.
package mfb_pkg;

	// Command codes carried in the low bits of the input word
	typedef enum logic [2:0] {
		CMD_PIXEL     = 3'd0,
		CMD_HLINE     = 3'd1,
		CMD_VLINE     = 3'd2,
		CMD_RECT      = 3'd3,
		CMD_BLIT_OPEN = 3'd4,
		CMD_BLIT_BYTE = 3'd5,
		CMD_READ      = 3'd6,
		CMD_NOP       = 3'd7
	} cmd_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SETUP,
		ST_ROWINIT,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;

	// Input and output word widths and coordinate widths
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 16;
	localparam int COORD_W     = 10;
	localparam int SCOORD_W    = 12;

	// Commands from controller to datapath
	typedef struct packed {
		logic clr_step;
		logic latch;
		logic setup;
		logic row_init;
		logic rd;
		logic wr;
		logic next_region;
		logic blit_open;
		logic blit_byte;
		logic read_req;
		logic out_load;
	} ctrl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_last;
		cmd_t cmd;
		logic region_empty;
		logic byte_last;
		logic row_last;
		logic region_last;
	} stat_t;

	// Pixel mask for pixels lo..hi of a byte, leftmost pixel in bit 7
	function automatic logic [7:0] fill_mask(input logic [2:0] lo, input logic [2:0] hi);
		logic [7:0] m;
		m = 8'h00;
		for (int p = 0; p < 8; p++) begin
			if (3'(p) >= lo && 3'(p) <= hi)
				m[7 - p] = 1'b1;
		end
		return m;
	endfunction

	// Bit reversal of one byte
	function automatic logic [7:0] reverse8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[7 - i] = b[i];
		return r;
	endfunction

endpackage

// File: hdl/mono_framebuffer_draw_engine.sv
// Top level of the monochrome framebuffer draw engine.
// One word on s_tdata is one drawing command; each command returns exactly one
// result word on m_tdata (read-back byte, clipped flag, status).
// The framebuffer is ROW_COUNT rows of ROW_BYTES bytes, one bit per pixel,
// leftmost pixel in bit 7, held in a single-port-write memory.
// After reset the memory is swept to zero, one byte per cycle; s_tready
// stays low during the sweep.
// After a command is accepted, blit open, blit byte, read and the unused
// code go from dispatch straight to the result load. A fill goes through
// setup and row init, then one memory read and one masked write per
// framebuffer byte touched, then loads the result. A rectangle outline runs
// four regions per unit of thickness; each region after the first goes
// through setup and row init again before its bytes.
// Commands are handled one at a time; the next word is taken the cycle after
// the current result is loaded. A finished result sits in the output register
// while the next command is accepted and worked on; if m_tready stays low, that
// command waits at its end until the output register is free.
module mono_framebuffer_draw_engine import mfb_pkg::*; #(
	parameter int ROW_BYTES = 16,
	parameter int ROW_COUNT = 296
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// command[2:0], pos_x[12:3], pos_y[22:13], span_w[32:23], span_h[42:33],
	// thickness[52:43], colour[53], image_byte[61:54], zero[63:62]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_data[7:0], clipped[8], status[9], zero[15:10]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	ctrl_t ctl;
	stat_t st;

	mfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.st        (st),
		.ctl       (ctl)
	);

	mfb_dp #(
		.ROW_BYTES (ROW_BYTES),
		.ROW_COUNT (ROW_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (s_tdata),
		.ctl      (ctl),
		.st       (st),
		.out_word (m_tdata)
	);

endmodule

// File: hdl/mfb_dp.sv
// Datapath of the draw engine: framebuffer memory, region walker, blit state and result register.
module mfb_dp import mfb_pkg::*; #(
	parameter int ROW_BYTES = 16,
	parameter int ROW_COUNT = 296
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  in_word,
	input  ctrl_t                  ctl,
	output stat_t                  st,
	output logic [OUT_TDATA_W-1:0] out_word
);

	localparam int DEPTH = ROW_BYTES * ROW_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIX_W = 8 * ROW_BYTES;
	localparam logic signed [SCOORD_W-1:0] PIX_W_S = SCOORD_W'(PIX_W);
	localparam logic signed [SCOORD_W-1:0] ROWS_S  = SCOORD_W'(ROW_COUNT);

	// Latched command word
	cmd_t               cmd_q;
	logic [COORD_W-1:0] x_q, y_q, w_q, h_q, t_q;
	logic               c_q;
	logic [7:0]         img_q;
	logic               clip_q, stat_q;

	// Outline iteration
	logic [COORD_W-1:0] k_q;
	logic [1:0]         sub_q;

	// Clamped region and walker
	logic [COORD_W-1:0] cx0_q, cx1_q, cy0_q, cy1_q;
	logic               empty_q;
	logic [COORD_W-1:0] row_q;
	logic [6:0]         byte_q;
	logic [AW-1:0]      base_q;

	// Blit state
	logic               blit_active_q;
	logic [10:0]        blit_row_q, blit_col_q, blit_first_q;
	logic [9:0]         blit_width_q, blit_rows_q;
	logic               blit_colour_q;

	// Memory and clear sweep
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] clr_q;

	// Region of the current fill pass
	logic signed [SCOORD_W-1:0] xs, ys, xw, yh, kk;
	logic signed [SCOORD_W-1:0] rx0, rx1, ry0, ry1;
	always_comb begin
		xs = SCOORD_W'(signed'({2'b00, x_q}));
		ys = SCOORD_W'(signed'({2'b00, y_q}));
		kk = SCOORD_W'(signed'({2'b00, k_q}));
		xw = xs + SCOORD_W'(signed'({2'b00, w_q}));
		yh = ys + SCOORD_W'(signed'({2'b00, h_q}));
		rx0 = xs; rx1 = xs; ry0 = ys; ry1 = ys;
		case (cmd_q)
			CMD_HLINE: begin
				rx1 = xw;
			end
			CMD_VLINE: begin
				ry1 = yh;
			end
			CMD_RECT: begin
				if (t_q == '0) begin
					rx1 = xw; ry1 = yh;
				end else begin
					case (sub_q)
						2'd0: begin
							rx1 = xw; ry0 = ys + kk; ry1 = ys + kk;
						end
						2'd1: begin
							rx1 = xw; ry0 = yh - kk; ry1 = yh - kk;
						end
						2'd2: begin
							rx0 = xs + kk; rx1 = xs + kk; ry1 = yh;
						end
						default: begin
							rx0 = xw - kk; rx1 = xw - kk; ry1 = yh;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Clamp to the buffer
	logic                       nonempty, clip_c;
	logic signed [SCOORD_W-1:0] cx0, cx1, cy0, cy1;
	always_comb begin
		nonempty = (rx0 <= rx1) && (ry0 <= ry1);
		clip_c = nonempty && (rx0 < 0 || ry0 < 0 || rx1 >= PIX_W_S || ry1 >= ROWS_S);
		cx0 = (rx0 < 0) ? '0 : rx0;
		cy0 = (ry0 < 0) ? '0 : ry0;
		cx1 = (rx1 >= PIX_W_S) ? PIX_W_S - SCOORD_W'(1) : rx1;
		cy1 = (ry1 >= ROWS_S) ? ROWS_S - SCOORD_W'(1) : ry1;
	end

	// Walker decode
	logic          byte_last, row_last;
	logic [2:0]    lo, hi;
	logic [7:0]    mask;
	logic [AW-1:0] fill_addr;
	assign byte_last = (byte_q == cx1_q[9:3]);
	assign row_last  = (row_q == cy1_q);
	assign lo        = (byte_q == cx0_q[9:3]) ? cx0_q[2:0] : 3'd0;
	assign hi        = byte_last ? cx1_q[2:0] : 3'd7;
	assign mask      = fill_mask(lo, hi);
	assign fill_addr = base_q + AW'(byte_q);

	// Read-back and blit addressing
	logic          read_in, blit_in;
	logic [AW-1:0] read_addr, blit_addr;
	logic [7:0]    blit_data;
	logic [10:0]   blit_col_n;
	assign read_in   = (32'(y_q) < ROW_COUNT) && (32'(x_q) < ROW_BYTES);
	assign read_addr = AW'(32'(y_q) * ROW_BYTES + 32'(x_q));
	assign blit_in   = (32'(blit_row_q) < ROW_COUNT) && (32'(blit_col_q) < ROW_BYTES);
	assign blit_addr = AW'(32'(blit_row_q) * ROW_BYTES + 32'(blit_col_q));
	assign blit_data = blit_colour_q ? reverse8(img_q) : ~reverse8(img_q);
	assign blit_col_n = blit_col_q + 11'd1;

	// Memory port selection
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	always_comb begin
		we = 1'b0; waddr = fill_addr; wdata = '0;
		if (ctl.clr_step) begin
			we = 1'b1; waddr = clr_q;
		end else if (ctl.wr) begin
			we = 1'b1;
			wdata = c_q ? (rdata_q | mask) : (rdata_q & ~mask);
		end else if (ctl.blit_byte && blit_active_q && blit_in) begin
			we = 1'b1; waddr = blit_addr; wdata = blit_data;
		end
		re = ctl.rd || (ctl.read_req && read_in);
		raddr = ctl.read_req ? read_addr : fill_addr;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// Clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Command word, flags and outline counters
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd_t'(in_word[2:0]);
			x_q    <= in_word[12:3];
			y_q    <= in_word[22:13];
			w_q    <= in_word[32:23];
			h_q    <= in_word[42:33];
			t_q    <= in_word[52:43];
			c_q    <= in_word[53];
			img_q  <= in_word[61:54];
			clip_q <= 1'b0;
			stat_q <= 1'b0;
			k_q    <= '0;
			sub_q  <= '0;
		end else begin
			if (ctl.setup && clip_c)
				clip_q <= 1'b1;
			if (ctl.read_req && !read_in)
				clip_q <= 1'b1;
			if (ctl.blit_byte) begin
				if (!blit_active_q)
					stat_q <= 1'b1;
				else if (!blit_in)
					clip_q <= 1'b1;
			end
			if (ctl.next_region) begin
				sub_q <= sub_q + 2'd1;
				if (sub_q == 2'd3)
					k_q <= k_q + COORD_W'(1);
			end
		end
	end

	// Region setup and walker
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			cx0_q   <= cx0[9:0];
			cx1_q   <= cx1[9:0];
			cy0_q   <= cy0[9:0];
			cy1_q   <= cy1[9:0];
			empty_q <= !nonempty || (cx0 > cx1) || (cy0 > cy1);
		end
		if (ctl.row_init) begin
			row_q  <= cy0_q;
			base_q <= AW'(32'(cy0_q) * ROW_BYTES);
			byte_q <= cx0_q[9:3];
		end else if (ctl.wr) begin
			if (byte_last) begin
				byte_q <= cx0_q[9:3];
				row_q  <= row_q + COORD_W'(1);
				base_q <= base_q + AW'(ROW_BYTES);
			end else begin
				byte_q <= byte_q + 7'd1;
			end
		end
	end

	// Blit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blit_active_q <= 1'b0;
			blit_row_q    <= '0;
			blit_col_q    <= '0;
			blit_first_q  <= '0;
			blit_width_q  <= '0;
			blit_rows_q   <= '0;
			blit_colour_q <= 1'b0;
		end else if (ctl.blit_open) begin
			blit_first_q  <= {4'b0, x_q[9:3]};
			blit_col_q    <= {4'b0, x_q[9:3]};
			blit_row_q    <= {1'b0, y_q};
			blit_width_q  <= w_q;
			blit_rows_q   <= h_q;
			blit_colour_q <= c_q;
			blit_active_q <= (w_q != '0) && (h_q != '0);
		end else if (ctl.blit_byte && blit_active_q) begin
			if ((blit_col_n - blit_first_q) >= {1'b0, blit_width_q}) begin
				blit_col_q  <= blit_first_q;
				blit_row_q  <= blit_row_q + 11'd1;
				blit_rows_q <= blit_rows_q - 10'd1;
				if (blit_rows_q == 10'd1)
					blit_active_q <= 1'b0;
			end else begin
				blit_col_q <= blit_col_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_word[7:0] <= (cmd_q == CMD_READ && !clip_q) ? rdata_q : 8'h00;
			out_word[8]   <= clip_q;
			out_word[9]   <= stat_q;
			out_word[15:10] <= '0;
		end
	end

	// Status to controller
	always_comb begin
		st.clear_last   = (clr_q == AW'(DEPTH - 1));
		st.cmd          = cmd_q;
		st.region_empty = empty_q;
		st.byte_last    = byte_last;
		st.row_last     = row_last;
		st.region_last  = !(cmd_q == CMD_RECT && t_q != '0) ||
			(sub_q == 2'd3 && k_q == t_q - COORD_W'(1));
	end

endmodule

// File: hdl/mfb_ctrl.sv
// Controller state machine of the draw engine: sequences clear sweep, fills, blits and reads.
module mfb_ctrl import mfb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t st,
	output ctrl_t ctl
);

	state_t state_q, state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (st.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (st.cmd)
					CMD_PIXEL, CMD_HLINE, CMD_VLINE, CMD_RECT: begin
						state_d = ST_SETUP;
					end
					CMD_BLIT_OPEN: begin
						ctl.blit_open = 1'b1;
						state_d = ST_DONE;
					end
					CMD_BLIT_BYTE: begin
						ctl.blit_byte = 1'b1;
						state_d = ST_DONE;
					end
					CMD_READ: begin
						ctl.read_req = 1'b1;
						state_d = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SETUP: begin
				ctl.setup = 1'b1;
				state_d   = ST_ROWINIT;
			end
			ST_ROWINIT: begin
				ctl.row_init = 1'b1;
				if (!st.region_empty) begin
					state_d = ST_RD;
				end else if (st.region_last) begin
					state_d = ST_DONE;
				end else begin
					ctl.next_region = 1'b1;
					state_d = ST_SETUP;
				end
			end
			ST_RD: begin
				ctl.rd  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				ctl.wr = 1'b1;
				if (!(st.byte_last && st.row_last)) begin
					state_d = ST_RD;
				end else if (st.region_last) begin
					state_d = ST_DONE;
				end else begin
					ctl.next_region = 1'b1;
					state_d = ST_SETUP;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
